// File: rtl/ogrc_pkg.sv
// Package for the occupancy grid ray count update block.
// Holds grid constants, beat payload types, controller codes and helper functions.
// No dependencies; every other file imports this package.
package ogrc_pkg;

   // Grid geometry and counter width.
   localparam int GRID_WIDTH  = 256;
   localparam int GRID_HEIGHT = 256;
   localparam int COUNT_BITS  = 16;

   // Derived widths.
   localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
   localparam int ADDR_BITS  = $clog2(CELL_COUNT);
   localparam int X_BITS     = $clog2(GRID_WIDTH);
   localparam int Y_BITS     = $clog2(GRID_HEIGHT);
   localparam int XY_BITS    = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
   localparam int ERR_BITS   = XY_BITS + 2;
   localparam int TOTAL_BITS = COUNT_BITS + 1;
   localparam int PROD_BITS  = COUNT_BITS + 8;

   // Fixed field widths of the beats.
   localparam int COORD_BITS  = 12;
   localparam int OUT_CNT_BITS = 16;
   localparam int WALK_BITS   = 9;
   localparam int PCT_BITS    = 7;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [COUNT_BITS-1:0]   COUNT_MAX   = {COUNT_BITS{1'b1}};
   localparam logic [OUT_CNT_BITS-1:0] OUT_CNT_MAX = {OUT_CNT_BITS{1'b1}};
   localparam logic [WALK_BITS-1:0]    WALK_MAX    = {WALK_BITS{1'b1}};
   localparam logic [PCT_BITS-1:0]     PCT_SCALE   = 7'd100;

   // Register indexes and reset values.
   localparam logic [CSR_IDX_BITS-1:0] CSR_OCCUPIED_PCT = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FREE_PCT     = 1'b1;
   localparam logic [PCT_BITS-1:0]     OCCUPIED_PCT_RST = 7'd65;
   localparam logic [PCT_BITS-1:0]     FREE_PCT_RST     = 7'd35;

   typedef enum logic {
      OP_TRACE = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STAT_TRACED   = 2'd0,
      STAT_SKIPPED  = 2'd1,
      STAT_READ     = 2'd2,
      STAT_OFF_GRID = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CLASS_UNKNOWN  = 2'd0,
      CLASS_FREE     = 2'd1,
      CLASS_OCCUPIED = 2'd2
   } class_type;

   typedef struct packed {
      op_type                        operation;
      logic signed [COORD_BITS-1:0]  start_x;
      logic signed [COORD_BITS-1:0]  start_y;
      logic signed [COORD_BITS-1:0]  end_x;
      logic signed [COORD_BITS-1:0]  end_y;
   } req_type;

   typedef struct packed {
      status_type              status;
      class_type               cell_class;
      logic [OUT_CNT_BITS-1:0] hit_count;
      logic [OUT_CNT_BITS-1:0] pass_count;
      logic [WALK_BITS-1:0]    cells_walked;
   } rsp_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_WALK,
      ST_END_READ,
      ST_END_WRITE,
      ST_CELL_READ,
      ST_CELL_WAIT,
      ST_CELL_CLASS,
      ST_DONE
   } state_type;

   // Which result the datapath captures.
   typedef enum logic [2:0] {
      RES_NONE,
      RES_SKIP,
      RES_OFF,
      RES_TRACE,
      RES_READ
   } res_sel_type;

   typedef struct packed {
      logic        clear_en;
      logic        latch_req;
      logic        walk_step;
      logic        count_walk;
      logic        hit_write;
      logic        class_mul;
      res_sel_type res_sel;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic is_read;
      logic start_on;
      logic end_on;
      logic at_end;
   } sts_type;

   // True when a signed column lies on the grid.
   function automatic logic x_on_grid(logic signed [COORD_BITS-1:0] v);
      return !v[COORD_BITS-1] && ({1'b0, v} < (COORD_BITS+1)'(GRID_WIDTH));
   endfunction

   // True when a signed row lies on the grid.
   function automatic logic y_on_grid(logic signed [COORD_BITS-1:0] v);
      return !v[COORD_BITS-1] && ({1'b0, v} < (COORD_BITS+1)'(GRID_HEIGHT));
   endfunction

   // Row-major cell address.
   function automatic logic [ADDR_BITS-1:0] cell_addr(logic [X_BITS-1:0] x,
                                                      logic [Y_BITS-1:0] y);
      return ADDR_BITS'(ADDR_BITS'(y) * ADDR_BITS'(GRID_WIDTH)) + ADDR_BITS'(x);
   endfunction

   // Counter increment that sticks at the maximum.
   function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

   // Clip a counter to the 16-bit result field.
   function automatic logic [OUT_CNT_BITS-1:0] clip_out(logic [COUNT_BITS-1:0] v);
      if (33'(v) > 33'(OUT_CNT_MAX)) begin
         return OUT_CNT_MAX;
      end else begin
         return OUT_CNT_BITS'(v);
      end
   endfunction

endpackage

// File: rtl/ogrc_ctrl.sv
// Controller for the occupancy grid ray count update block.
// Sequences clearing, ray walks and cell reads; owns the result valid flag.
// Depends on ogrc_pkg.
module ogrc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  ogrc_pkg::sts_type sts,
   output ogrc_pkg::cmd_type cmd
);
   import ogrc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.res_sel = RES_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.is_read) begin
               if (sts.end_on) begin
                  state_in = ST_CELL_READ;
               end else begin
                  cmd.res_sel = RES_OFF;
                  state_in    = ST_DONE;
               end
            end else if (sts.start_on && sts.end_on) begin
               state_in = ST_WALK;
            end else begin
               cmd.res_sel = RES_SKIP;
               state_in    = ST_DONE;
            end
         end
         ST_WALK: begin
            cmd.count_walk = 1'b1;
            if (sts.at_end) begin
               state_in = ST_END_READ;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         ST_END_READ: begin
            state_in = ST_END_WRITE;
         end
         ST_END_WRITE: begin
            cmd.hit_write = 1'b1;
            cmd.res_sel   = RES_TRACE;
            state_in      = ST_DONE;
         end
         ST_CELL_READ: begin
            state_in = ST_CELL_WAIT;
         end
         ST_CELL_WAIT: begin
            cmd.class_mul = 1'b1;
            state_in      = ST_CELL_CLASS;
         end
         ST_CELL_CLASS: begin
            cmd.res_sel = RES_READ;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result beat valid flag.
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // A loaded result is offered on the next cycle.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("result load did not raise rsp_valid");

   // The walk never steps past the end cell.
   a_no_step_at_end: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> !sts.at_end)
      else $error("walk stepped at the end cell");
`endif

endmodule

// File: rtl/ogrc_dpath.sv
// Datapath for the occupancy grid ray count update block.
// Holds the count memories, line stepper, classifier, registers and result register.
// Depends on ogrc_pkg.
module ogrc_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  ogrc_pkg::req_type                req_payload,
   input  logic                            csr_write_en,
   input  logic [ogrc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [ogrc_pkg::PCT_BITS-1:0]     csr_wdata,
   input  ogrc_pkg::cmd_type                cmd,
   output ogrc_pkg::sts_type                sts,
   output ogrc_pkg::rsp_type                rsp_payload
);
   import ogrc_pkg::*;

   // Count memories.
   logic [COUNT_BITS-1:0] hit_mem  [CELL_COUNT];
   logic [COUNT_BITS-1:0] pass_mem [CELL_COUNT];
   logic [COUNT_BITS-1:0] hit_rd_ff, pass_rd_ff;

   // Configuration registers.
   logic [PCT_BITS-1:0] occ_pct_ff, free_pct_ff;

   // Clearing pass.
   logic [ADDR_BITS-1:0] clr_addr_ff;

   // Latched item and line stepper.
   op_type                    op_ff;
   logic                      start_on_ff, end_on_ff;
   logic [X_BITS-1:0]         cx_ff, ex_ff, dx_ff;
   logic [Y_BITS-1:0]         cy_ff, ey_ff, dy_ff;
   logic                      stx_neg_ff, sty_neg_ff;
   logic signed [ERR_BITS-1:0] err_ff;
   logic [WALK_BITS-1:0]      walked_ff;

   // Pending pass write, made in the cycle after its read.
   logic                 wr_pend_ff;
   logic [ADDR_BITS-1:0] wr_addr_ff;

   // Classifier registers.
   logic                  zero_ff;
   logic [COUNT_BITS-1:0] h_ff, p_ff;
   logic [PROD_BITS-1:0]  hprod_ff, oprod_ff, fprod_ff;

   // Result being built and output register.
   status_type              res_status_ff;
   class_type               res_class_ff;
   logic [OUT_CNT_BITS-1:0] res_hit_ff, res_pass_ff;
   rsp_type                 rsp_ff;

   logic [ADDR_BITS-1:0] cur_addr, end_addr, rd_addr;
   logic [COUNT_BITS-1:0] hit_inc;

   assign cur_addr = cell_addr(cx_ff, cy_ff);
   assign end_addr = cell_addr(ex_ff, ey_ff);
   assign rd_addr  = cmd.walk_step ? cur_addr : end_addr;
   assign hit_inc  = sat_inc(hit_rd_ff);

   // Status to the controller.
   always_comb begin
      sts.clear_done = (clr_addr_ff == ADDR_BITS'(CELL_COUNT - 1));
      sts.is_read    = (op_ff == OP_READ);
      sts.start_on   = start_on_ff;
      sts.end_on     = end_on_ff;
      sts.at_end     = (cx_ff == ex_ff) && (cy_ff == ey_ff);
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_pct_ff  <= OCCUPIED_PCT_RST;
         free_pct_ff <= FREE_PCT_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_OCCUPIED_PCT: occ_pct_ff  <= csr_wdata;
            CSR_FREE_PCT:     free_pct_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clearing pass address.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_en && !sts.clear_done) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // Hit memory: clearing, end cell update, registered read.
   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         hit_mem[clr_addr_ff] <= '0;
      end else if (cmd.hit_write) begin
         hit_mem[end_addr] <= hit_inc;
      end
      hit_rd_ff <= hit_mem[rd_addr];
   end

   // Pass memory: clearing, walk updates, registered read.
   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         pass_mem[clr_addr_ff] <= '0;
      end else if (wr_pend_ff) begin
         pass_mem[wr_addr_ff] <= sat_inc(pass_rd_ff);
      end
      pass_rd_ff <= pass_mem[rd_addr];
   end

   // Pending pass write control.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pend_ff <= 1'b0;
      end else begin
         wr_pend_ff <= cmd.walk_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_step) begin
         wr_addr_ff <= cur_addr;
      end
   end

   // Item latch and Bresenham stepping.
   logic signed [X_BITS:0]   ddx;
   logic signed [Y_BITS:0]   ddy;
   logic signed [ERR_BITS:0] e2, dx_e, dy_e;
   logic                     step_x, step_y;
   logic signed [ERR_BITS-1:0] err_next;

   always_comb begin
      ddx  = $signed({1'b0, X_BITS'(req_payload.end_x)})
           - $signed({1'b0, X_BITS'(req_payload.start_x)});
      ddy  = $signed({1'b0, Y_BITS'(req_payload.end_y)})
           - $signed({1'b0, Y_BITS'(req_payload.start_y)});
      e2   = {err_ff, 1'b0};
      dx_e = (ERR_BITS+1)'(dx_ff);
      dy_e = (ERR_BITS+1)'(dy_ff);
      step_x = (e2 > -dy_e);
      step_y = (e2 < dx_e);
      err_next = err_ff;
      if (step_x) begin
         err_next = err_next - ERR_BITS'(dy_ff);
      end
      if (step_y) begin
         err_next = err_next + ERR_BITS'(dx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff       <= req_payload.operation;
         start_on_ff <= x_on_grid(req_payload.start_x) && y_on_grid(req_payload.start_y);
         end_on_ff   <= x_on_grid(req_payload.end_x) && y_on_grid(req_payload.end_y);
         cx_ff       <= X_BITS'(req_payload.start_x);
         cy_ff       <= Y_BITS'(req_payload.start_y);
         ex_ff       <= X_BITS'(req_payload.end_x);
         ey_ff       <= Y_BITS'(req_payload.end_y);
         dx_ff       <= ddx[X_BITS] ? X_BITS'(-ddx) : X_BITS'(ddx);
         dy_ff       <= ddy[Y_BITS] ? Y_BITS'(-ddy) : Y_BITS'(ddy);
         stx_neg_ff  <= ddx[X_BITS] || (ddx == '0);
         sty_neg_ff  <= ddy[Y_BITS] || (ddy == '0);
         err_ff      <= ERR_BITS'(ddx[X_BITS] ? -ddx : ddx)
                      - ERR_BITS'(ddy[Y_BITS] ? -ddy : ddy);
      end else if (cmd.walk_step) begin
         if (step_x) begin
            cx_ff <= stx_neg_ff ? cx_ff - 1'b1 : cx_ff + 1'b1;
         end
         if (step_y) begin
            cy_ff <= sty_neg_ff ? cy_ff - 1'b1 : cy_ff + 1'b1;
         end
         err_ff <= err_next;
      end
   end

   // Cells walked, saturating.
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         walked_ff <= '0;
      end else if (cmd.count_walk && (walked_ff != WALK_MAX)) begin
         walked_ff <= walked_ff + 1'b1;
      end
   end

   // Classifier products.
   logic [TOTAL_BITS-1:0] total;
   assign total = TOTAL_BITS'(hit_rd_ff) + TOTAL_BITS'(pass_rd_ff);

   always_ff @(posedge clock) begin
      if (cmd.class_mul) begin
         h_ff     <= hit_rd_ff;
         p_ff     <= pass_rd_ff;
         zero_ff  <= (total == '0);
         hprod_ff <= PROD_BITS'(hit_rd_ff) * PROD_BITS'(PCT_SCALE);
         oprod_ff <= PROD_BITS'(occ_pct_ff) * PROD_BITS'(total);
         fprod_ff <= PROD_BITS'(free_pct_ff) * PROD_BITS'(total);
      end
   end

   // Result capture.
   always_ff @(posedge clock) begin
      case (cmd.res_sel)
         RES_SKIP: begin
            res_status_ff <= STAT_SKIPPED;
            res_class_ff  <= CLASS_UNKNOWN;
            res_hit_ff    <= '0;
            res_pass_ff   <= '0;
         end
         RES_OFF: begin
            res_status_ff <= STAT_OFF_GRID;
            res_class_ff  <= CLASS_UNKNOWN;
            res_hit_ff    <= '0;
            res_pass_ff   <= '0;
         end
         RES_TRACE: begin
            res_status_ff <= STAT_TRACED;
            res_class_ff  <= CLASS_UNKNOWN;
            res_hit_ff    <= clip_out(hit_inc);
            res_pass_ff   <= clip_out(pass_rd_ff);
         end
         RES_READ: begin
            res_status_ff <= STAT_READ;
            // Occupied wins when both tests pass.
            if (zero_ff) begin
               res_class_ff <= CLASS_UNKNOWN;
            end else if (hprod_ff > oprod_ff) begin
               res_class_ff <= CLASS_OCCUPIED;
            end else if (hprod_ff < fprod_ff) begin
               res_class_ff <= CLASS_FREE;
            end else begin
               res_class_ff <= CLASS_UNKNOWN;
            end
            res_hit_ff  <= clip_out(h_ff);
            res_pass_ff <= clip_out(p_ff);
         end
         default: ;
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.status       <= res_status_ff;
         rsp_ff.cell_class   <= res_class_ff;
         rsp_ff.hit_count    <= res_hit_ff;
         rsp_ff.pass_count   <= res_pass_ff;
         rsp_ff.cells_walked <= walked_ff;
      end
   end

   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // A line never revisits a cell, so the delayed pass write and the read differ.
   a_no_rmw_clash: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff && cmd.walk_step |-> wr_addr_ff != cur_addr)
      else $error("pass write collides with walk read");

   // The end cell update always follows a walk of at least one cell.
   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.hit_write |-> walked_ff != '0)
      else $error("hit update without a walked cell");
`endif

endmodule

// File: rtl/occupancy_grid_ray_count_update.sv
// Top level of the occupancy grid ray count update block.
// Joins the controller and the datapath; depends on ogrc_pkg, ogrc_ctrl, ogrc_dpath.
//
//   channel  ports                                    beat
//   req      req_valid / req_ready / req_payload      one trace or read item
//   rsp      rsp_valid / rsp_ready / rsp_payload      one result per item
//   csr      csr_write_en / csr_index / csr_wdata     register write, no wait
//
// A trace passes check, the walk, end read, end write and done, one cell per cycle in
// the walk as the pass memory read-modify-write is pipelined; a read passes check,
// cell read, cell wait, class and done; a skipped ray or off-grid read goes to done.
// After reset a clearing pass writes both count memories, one cell a cycle, over all
// GRID_WIDTH * GRID_HEIGHT cells (65536); no item is accepted until it ends.
// A result waits in the output register while the next item is accepted and
// worked on; the controller stalls only when it must load a new result.
module occupancy_grid_ray_count_update (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ogrc_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ogrc_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_write_en,
   input  logic [ogrc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [ogrc_pkg::PCT_BITS-1:0]     csr_wdata
);
   import ogrc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer.
   ogrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Memories, stepper and classifier.
   ogrc_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_payload  (req_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_payload  (rsp_payload)
   );

endmodule
